FILE: rtl/doem_pkg.sv
// ============================================================================
// doem_pkg: shared types and constants of the one-edit dictionary matcher
// Letter layout, result status codes, request codes, and the command and
// status bundles that run between the controller and the datapath.
// ============================================================================
package doem_pkg;

  localparam int LETTERS  = 15;
  localparam int LETTER_W = 5;
  localparam int LEN_W    = 4;
  localparam int FRONT_W  = 40;
  localparam int BACK_W   = 35;
  localparam int ENTRY_W  = 10;
  localparam int STATUS_W = 3;

  // Letter k sits at bits [5k+4:5k]; front letters are the low part.
  typedef logic [LETTERS-1:0][LETTER_W-1:0] letters_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_CORRECT = 3'd2,
    ST_SUGGEST = 3'd3,
    ST_NONE    = 3'd4
  } status_t;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  typedef struct packed {
    logic load;
    logic query;
    logic step;
    logic restart;
    logic take_exact;
    logic take_sugg;
    logic push_pend;
    logic set_none;
    logic set_trunc;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic rd_valid;
    logic exact_hit;
    logic edit_hit;
    logic pend_valid;
    logic sugg_full;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/doem_if.sv
// ============================================================================
// doem_if: request and response channels of the one-edit dictionary matcher
// Each channel carries valid, ready and its payload fields.
// ============================================================================
interface doem_req_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic [doem_pkg::LEN_W-1:0]         word_len;
  logic [doem_pkg::FRONT_W-1:0]       word_front;
  logic [doem_pkg::BACK_W-1:0]        word_back;

  modport source (output valid, req_type, word_len, word_front, word_back, input ready);
  modport sink   (input valid, req_type, word_len, word_front, word_back, output ready);
endinterface

interface doem_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [doem_pkg::STATUS_W-1:0]      status;
  logic [doem_pkg::ENTRY_W-1:0]       entry_index;
  logic                               last;
  logic                               truncated;

  modport source (output valid, status, entry_index, last, truncated, input ready);
  modport sink   (input valid, status, entry_index, last, truncated, output ready);
endinterface

FILE: rtl/doem_ram.sv
// ============================================================================
// doem_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds while
// the read enable is low.
// ============================================================================
module doem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/doem_ctrl.sv
// ============================================================================
// doem_ctrl: sequencer of the one-edit dictionary matcher
// Steps each request through the exact-match pass, the one-edit pass and the
// final result, driving the datapath by commands.
// ============================================================================
module doem_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_req_type,
  output logic           in_ready,
  input  doem_pkg::sts_t sts,
  output doem_pkg::cmd_t cmd
);
  import doem_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXACT,
    S_SUGGEST,
    S_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_LOAD) begin
            cmd.load   = 1'b1;
            state_next = S_FLUSH;
          end else begin
            cmd.query  = 1'b1;
            state_next = S_EXACT;
          end
        end
      end
      S_EXACT: begin
        if (sts.rd_valid && sts.exact_hit) begin
          cmd.take_exact = 1'b1;
          state_next     = S_FLUSH;
        end else if (sts.scan_done) begin
          cmd.restart = 1'b1;
          state_next  = S_SUGGEST;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SUGGEST: begin
        if (sts.rd_valid && sts.edit_hit) begin
          if (!sts.pend_valid) begin
            cmd.take_sugg = 1'b1;
            cmd.step      = 1'b1;
          end else if (sts.sugg_full) begin
            cmd.set_trunc = 1'b1;
            state_next    = S_FLUSH;
          end else if (sts.out_free) begin
            cmd.push_pend = 1'b1;
            cmd.take_sugg = 1'b1;
            cmd.step      = 1'b1;
          end
          // Otherwise the scan holds until the output register frees up.
        end else if (sts.scan_done) begin
          cmd.set_none = !sts.pend_valid;
          state_next   = S_FLUSH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/doem_datapath.sv
// ============================================================================
// doem_datapath: dictionary store, entry scanner and word comparator
// Holds the dictionary RAM, the query word, the scan pipeline, the held
// result and the output register.
// ============================================================================
module doem_datapath #(
  parameter int DICT_DEPTH      = 1024,
  parameter int MAX_SUGGESTIONS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [doem_pkg::LEN_W-1:0]      word_len,
  input  logic [doem_pkg::FRONT_W-1:0]    word_front,
  input  logic [doem_pkg::BACK_W-1:0]     word_back,
  input  doem_pkg::cmd_t                  cmd,
  output doem_pkg::sts_t                  sts,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic [doem_pkg::STATUS_W-1:0]   rsp_status,
  output logic [doem_pkg::ENTRY_W-1:0]    rsp_entry_index,
  output logic                            rsp_last,
  output logic                            rsp_truncated
);
  import doem_pkg::*;

  localparam int AW = $clog2(DICT_DEPTH);
  localparam int CW = $clog2(DICT_DEPTH + 1);
  localparam int SW = $clog2(MAX_SUGGESTIONS + 1);
  localparam int DW = LEN_W + LETTERS * LETTER_W;

  // Dictionary fill and scan pointers.
  logic [CW-1:0]    entry_count;
  logic             full;
  logic [CW-1:0]    scan_addr;
  logic             issue;
  logic             rd_valid;
  logic [AW-1:0]    rd_idx;
  logic [DW-1:0]    rd_data;

  // Query and incoming word.
  letters_t         word_in;
  letters_t         word_masked;
  letters_t         q_letters;
  logic [LEN_W-1:0] q_len;
  letters_t         d_letters;
  logic [LEN_W-1:0] d_len;

  // Held result.
  logic             pend_valid;
  status_t          pend_status;
  logic [AW-1:0]    pend_idx;
  logic             trunc;
  logic [SW-1:0]    sugg_count;

  // Comparator.
  logic [LETTERS-1:0] mm;
  logic [LETTERS-1:0] eq_a;
  logic [LETTERS-1:0] eq_b;
  logic [LETTERS-1:0] bad;
  letters_t           s_word;
  letters_t           l_word;
  logic [LEN_W-1:0]   s_len;
  logic               len_eq;
  logic               q_short;
  logic               d_short;
  logic               exact_hit;
  logic               sub_hit;
  logic               ins_hit;

  assign word_in = letters_t'({word_back, word_front});

  // Letters past the word length are cleared before storing or comparing.
  always_comb begin
    for (int k = 0; k < LETTERS; k++) begin
      word_masked[k] = (LEN_W'(k) < word_len) ? word_in[k] : '0;
    end
  end

  assign full  = (entry_count == CW'(DICT_DEPTH));
  assign issue = cmd.step && (scan_addr < entry_count);

  doem_ram #(
    .WIDTH (DW),
    .DEPTH (DICT_DEPTH)
  ) u_dict (
    .clk   (clk),
    .we    (cmd.load && !full),
    .waddr (entry_count[AW-1:0]),
    .wdata ({word_len, word_masked}),
    .re    (issue),
    .raddr (scan_addr[AW-1:0]),
    .rdata (rd_data)
  );

  assign d_len     = rd_data[DW-1 -: LEN_W];
  assign d_letters = letters_t'(rd_data[DW-LEN_W-1:0]);

  // A one-letter insertion or deletion holds when no mismatch of the aligned
  // prefix comes at or before a mismatch of the shifted suffix.
  always_comb begin
    for (int k = 0; k < LETTERS; k++) begin
      mm[k] = (q_letters[k] != d_letters[k]);
    end
    len_eq  = (q_len == d_len);
    q_short = (({1'b0, q_len} + 5'd1) == {1'b0, d_len});
    d_short = (({1'b0, d_len} + 5'd1) == {1'b0, q_len});
    if (q_short) begin
      s_word = q_letters;
      l_word = d_letters;
      s_len  = q_len;
    end else begin
      s_word = d_letters;
      l_word = q_letters;
      s_len  = d_len;
    end
    for (int k = 0; k < LETTERS; k++) begin
      eq_a[k] = (LEN_W'(k) >= s_len) || (s_word[k] == l_word[k]);
    end
    for (int k = 0; k < LETTERS - 1; k++) begin
      eq_b[k] = (LEN_W'(k) >= s_len) || (s_word[k] == l_word[k+1]);
    end
    eq_b[LETTERS-1] = 1'b1;
    for (int k = 0; k < LETTERS; k++) begin
      bad[k] = !eq_b[k] && (|(~eq_a & ((LETTERS'(2) << k) - LETTERS'(1))));
    end
    exact_hit = len_eq && (mm == '0);
    sub_hit   = len_eq && (mm != '0) && ((mm & (mm - LETTERS'(1))) == '0);
    ins_hit   = (q_short || d_short) && (bad == '0);
  end

  always_comb begin
    sts.scan_done  = !rd_valid && (scan_addr >= entry_count);
    sts.rd_valid   = rd_valid;
    sts.exact_hit  = exact_hit;
    sts.edit_hit   = sub_hit || ins_hit;
    sts.pend_valid = pend_valid;
    sts.sugg_full  = (sugg_count == SW'(MAX_SUGGESTIONS));
    sts.out_free   = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      scan_addr   <= '0;
      rd_valid    <= 1'b0;
      sugg_count  <= '0;
      pend_valid  <= 1'b0;
      trunc       <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cmd.load && !full) begin
        entry_count <= entry_count + CW'(1);
      end
      if (cmd.query || cmd.restart) begin
        scan_addr  <= '0;
        rd_valid   <= 1'b0;
        sugg_count <= '0;
      end else begin
        if (cmd.step) begin
          rd_valid <= issue;
          if (issue) begin
            scan_addr <= scan_addr + CW'(1);
          end
        end
        if (cmd.take_sugg) begin
          sugg_count <= sugg_count + SW'(1);
        end
      end
      if (cmd.query || cmd.flush) begin
        pend_valid <= 1'b0;
      end else if (cmd.load || cmd.take_exact || cmd.take_sugg || cmd.set_none) begin
        pend_valid <= 1'b1;
      end
      if (cmd.load || cmd.query) begin
        trunc <= 1'b0;
      end else if (cmd.set_trunc) begin
        trunc <= 1'b1;
      end
      if (cmd.push_pend || cmd.flush) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx <= scan_addr[AW-1:0];
    end
    if (cmd.query) begin
      q_letters <= word_masked;
      q_len     <= word_len;
    end
    if (cmd.load) begin
      pend_status <= full ? ST_FULL : ST_STORED;
      pend_idx    <= full ? '0 : entry_count[AW-1:0];
    end else if (cmd.take_exact) begin
      pend_status <= ST_CORRECT;
      pend_idx    <= rd_idx;
    end else if (cmd.take_sugg) begin
      pend_status <= ST_SUGGEST;
      pend_idx    <= rd_idx;
    end else if (cmd.set_none) begin
      pend_status <= ST_NONE;
      pend_idx    <= '0;
    end
    if (cmd.push_pend || cmd.flush) begin
      rsp_status      <= pend_status;
      rsp_entry_index <= ENTRY_W'(pend_idx);
      rsp_last        <= cmd.flush;
      rsp_truncated   <= cmd.flush && trunc;
    end
  end

endmodule

FILE: rtl/dictionary_one_edit_matcher.sv
// ============================================================================
// dictionary_one_edit_matcher: one-edit-distance dictionary lookup
// Loads words into a dictionary RAM and checks query words against it,
// reporting an exact match or the stored words one edit away, up to the limit.
// ============================================================================
// A load's result moves from the held result to the output register once the
// output is free. A query reads one entry per cycle in an exact pass, then in
// a one-edit pass that may pause while the output register is busy; an exact
// hit stops the scan at once, else the query ends after the one-edit pass or
// on truncation. Items run one at a time; the next can enter in the cycle
// after its closing result is registered. Reset clears only control state.
module dictionary_one_edit_matcher #(
  parameter int DICT_DEPTH      = 1024,
  parameter int MAX_SUGGESTIONS = 64
) (
  input  logic          clk,
  input  logic          rst,
  doem_req_if.sink      req,
  doem_rsp_if.source    rsp
);
  import doem_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // The sequencer walks each item through its phases: a load goes to its result,
  // a query runs the exact pass, then the one-edit pass unless an exact hit
  // ends it, and each closing result (last set) enters the output register.
  doem_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_req_type (req.req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  assign req.ready = in_ready;

  // The datapath holds the dictionary, compares one stored entry per cycle when
  // the scan is not held, and keeps one suggestion back so that the last flag
  // and the truncation flag can be set on the final item of a query.
  // The dictionary RAM is never cleared, since only slots below the entry
  // count are ever read.
  doem_datapath #(
    .DICT_DEPTH      (DICT_DEPTH),
    .MAX_SUGGESTIONS (MAX_SUGGESTIONS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .word_len        (req.word_len),
    .word_front      (req.word_front),
    .word_back       (req.word_back),
    .cmd             (cmd),
    .sts             (sts),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_entry_index (rsp.entry_index),
    .rsp_last        (rsp.last),
    .rsp_truncated   (rsp.truncated)
  );

endmodule

FILE: tb/dictionary_one_edit_matcher_tb.sv
// ============================================================================
// dictionary_one_edit_matcher_tb: self-checking bench for the one-edit matcher
// Loads words into the dictionary and fires queries at it. Every accepted
// request item is run through a bench-side copy of the dictionary that works
// out the expected replies. The replies are then checked field by field, in
// order. The run covers directed corner words, random word families built
// around a few base words and a suggestion overflow. Random back-pressure is
// applied on both channels.
// ============================================================================
module dictionary_one_edit_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import doem_pkg::*;

  // Sizes match the defaults of the block; they are passed explicitly below.
  localparam int DICT_SLOTS  = 1024;
  localparam int SUGG_LIMIT  = 64;
  localparam int RANDOM_REQS = 376;

  // A word as the stimulus side sees it: letters past len are always zero.
  typedef struct {
    letters_t letters;
    int       len;
  } word_t;

  // One request item as it goes onto the wire.
  typedef struct {
    logic               req_type;
    logic [LEN_W-1:0]   len;
    logic [FRONT_W-1:0] front;
    logic [BACK_W-1:0]  back;
  } word_req_t;

  // One reply item as the block should produce it.
  typedef struct {
    status_t            status;
    logic [ENTRY_W-1:0] entry;
    logic               last;
    logic               truncated;
  } reply_t;

  typedef enum int {
    EDIT_SUB,
    EDIT_DEL,
    EDIT_INS
  } edit_kind_t;

  logic clk;
  logic rst;

  doem_req_if req_ch ();
  doem_rsp_if rsp_ch ();

  dictionary_one_edit_matcher #(
    .DICT_DEPTH      (DICT_SLOTS),
    .MAX_SUGGESTIONS (SUGG_LIMIT)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Request items waiting to be driven, filled by the stimulus process.
  word_req_t pending_reqs[$];
  // Replies still owed by the block, oldest first.
  reply_t    awaited_replies[$];

  // Bench-side copy of the dictionary, updated as request items are accepted.
  letters_t  mirror_words [DICT_SLOTS];
  int        mirror_lens  [DICT_SLOTS];
  int        mirror_count = 0;

  // The stimulus side keeps its own list of the words it has asked to store,
  // so that it can build queries near them long before they are accepted.
  word_t     planned_words[$];
  word_t     base_words[$];

  // Percent of cycles in which each side holds back, set per phase.
  int        source_idle_pct = 12;
  int        sink_idle_pct   = 61;
  // While set, the response side refuses every item.
  bit        rsp_hold        = 1'b0;

  bit        req_fire        = 1'b0;
  int        mismatch_count  = 0;
  int        reply_count     = 0;

  // --------------------------------------------------------------------------
  // Clock and the overall time limit.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A correct run ends long before this limit.
  initial begin
    #100_000_000;
    $display("dictionary_one_edit_matcher_tb: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Mismatch reporting: one line per mismatch, and every one is counted.
  // --------------------------------------------------------------------------
  task automatic note_mismatch(string what);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Prediction.
  // --------------------------------------------------------------------------

  // Appends one expected reply behind those already owed.
  function automatic void expect_reply(status_t status, logic [ENTRY_W-1:0] entry,
                                       logic last, logic truncated);
    reply_t r;
    r.status    = status;
    r.entry     = entry;
    r.last      = last;
    r.truncated = truncated;
    awaited_replies.insert(awaited_replies.size(), r);
  endfunction

  // Zero every letter at or past len, since those are never stored or compared.
  function automatic letters_t clip_word(letters_t w, int len);
    letters_t c;
    int       k;
    c = w;
    for (k = 0; k < LETTERS; k++) begin
      if (k >= len) begin
        c[k] = '0;
      end
    end
    return c;
  endfunction

  // True when the two words are exactly one substitution, deletion or
  // insertion apart. Equal words give false.
  function automatic bit within_one_edit(letters_t qw, int ql, letters_t dw, int dl);
    letters_t shorter;
    letters_t longer;
    int       ls;
    int       ll;
    int       i;
    int       j;
    int       diffs;
    if (ql == dl) begin
      diffs = 0;
      for (i = 0; i < ql; i++) begin
        if (qw[i] != dw[i]) begin
          diffs++;
        end
      end
      return diffs == 1;
    end
    if (ql + 1 == dl) begin
      shorter = qw;
      ls      = ql;
      longer  = dw;
      ll      = dl;
    end else if (dl + 1 == ql) begin
      shorter = dw;
      ls      = dl;
      longer  = qw;
      ll      = ql;
    end else begin
      return 1'b0;
    end
    // The shorter word has to be a subsequence of the longer one.
    i = 0;
    for (j = 0; j < ll && i < ls; j++) begin
      if (shorter[i] == longer[j]) begin
        i++;
      end
    end
    return i == ls;
  endfunction

  // Works out the replies to one accepted request and queues them.
  function automatic void predict_matches(word_req_t r);
    letters_t qw;
    int       ln;
    int       e;
    int       k;
    int       hits[$];
    bit       dropped;
    ln = int'(r.len);
    qw = clip_word(letters_t'({r.back, r.front}), ln);

    if (r.req_type == REQ_LOAD) begin
      if (mirror_count >= DICT_SLOTS) begin
        expect_reply(ST_FULL, '0, 1'b1, 1'b0);
      end else begin
        mirror_words[mirror_count] = qw;
        mirror_lens[mirror_count]  = ln;
        expect_reply(ST_STORED, ENTRY_W'(mirror_count), 1'b1, 1'b0);
        mirror_count++;
      end
      return;
    end

    // An exact match wins over any suggestion; the lowest slot is reported.
    for (e = 0; e < mirror_count; e++) begin
      if (mirror_lens[e] == ln && mirror_words[e] == qw) begin
        expect_reply(ST_CORRECT, ENTRY_W'(e), 1'b1, 1'b0);
        return;
      end
    end

    // Gather one hit past the limit, so we know whether any were dropped.
    for (e = 0; e < mirror_count && hits.size() <= SUGG_LIMIT; e++) begin
      if (within_one_edit(qw, ln, mirror_words[e], mirror_lens[e])) begin
        hits.insert(hits.size(), e);
      end
    end
    dropped = hits.size() > SUGG_LIMIT;

    if (hits.size() == 0) begin
      expect_reply(ST_NONE, '0, 1'b1, 1'b0);
      return;
    end
    for (k = 0; k < hits.size() && k < SUGG_LIMIT; k++) begin
      if (k == hits.size() - 1 || k == SUGG_LIMIT - 1) begin
        expect_reply(ST_SUGGEST, ENTRY_W'(hits[k]), 1'b1, dropped);
      end else begin
        expect_reply(ST_SUGGEST, ENTRY_W'(hits[k]), 1'b0, 1'b0);
      end
    end
  endfunction

  // Compares one accepted reply with the oldest expectation.
  task automatic check_reply();
    reply_t want;
    if (awaited_replies.size() == 0) begin
      note_mismatch($sformatf("reply %0d not expected: status %0d index %0d",
                              reply_count, rsp_ch.status, rsp_ch.entry_index));
      reply_count++;
      return;
    end
    want = awaited_replies.pop_front();
    if (rsp_ch.status !== want.status) begin
      note_mismatch($sformatf("reply %0d status %0d, expected %0d",
                              reply_count, rsp_ch.status, want.status));
    end
    if (rsp_ch.entry_index !== want.entry) begin
      note_mismatch($sformatf("reply %0d entry_index %0d, expected %0d",
                              reply_count, rsp_ch.entry_index, want.entry));
    end
    if (rsp_ch.last !== want.last) begin
      note_mismatch($sformatf("reply %0d last %b, expected %b",
                              reply_count, rsp_ch.last, want.last));
    end
    if (rsp_ch.truncated !== want.truncated) begin
      note_mismatch($sformatf("reply %0d truncated %b, expected %b",
                              reply_count, rsp_ch.truncated, want.truncated));
    end
    reply_count++;
  endtask

  // --------------------------------------------------------------------------
  // Request driver. Inputs move on the falling edge; an item stays on the
  // wire until the rising edge at which valid and ready are both high.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : req_driver
    word_req_t next_req;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= source_idle_pct) begin
        next_req = pending_reqs.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= next_req.req_type;
        req_ch.word_len   <= next_req.len;
        req_ch.word_front <= next_req.front;
        req_ch.word_back  <= next_req.back;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response ready: random stalls, or a solid hold-off while rsp_hold is set.
  always @(negedge clk) begin
    if (rst || rsp_hold) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Everything is sampled on the rising edge. A reply accepted at
  // this edge always belongs to an earlier request item, so the check runs
  // before the prediction for a request accepted at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        check_reply();
      end
      if (req_ch.valid && req_ch.ready) begin
        predict_matches('{req_ch.req_type, req_ch.word_len, req_ch.word_front,
                          req_ch.word_back});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Word building for the stimulus.
  // --------------------------------------------------------------------------

  // Mostly real letters; now and then a code outside a..z, which the block
  // has to treat as just another symbol.
  function automatic logic [LETTER_W-1:0] random_letter();
    if ($urandom_range(9) != 0) begin
      return LETTER_W'($urandom_range(26, 1));
    end
    return ($urandom_range(5) == 0) ? '0 : LETTER_W'($urandom_range(31, 27));
  endfunction

  function automatic word_t random_word(int len);
    word_t w;
    int    k;
    w.letters = '0;
    w.len     = len;
    for (k = 0; k < len; k++) begin
      w.letters[k] = random_letter();
    end
    return w;
  endfunction

  function automatic word_t word_of(string s);
    word_t w;
    int    k;
    w.letters = '0;
    w.len     = s.len();
    for (k = 0; k < s.len(); k++) begin
      w.letters[k] = LETTER_W'(s[k] - 8'd96);
    end
    return w;
  endfunction

  // A word exactly one edit away from w, never equal to it.
  function automatic word_t edit_word(word_t w);
    word_t                v;
    edit_kind_t           kind;
    int                   pos;
    int                   k;
    logic [LETTER_W-1:0]  sym;
    v = w;
    do begin
      kind = edit_kind_t'($urandom_range(2));
    end while ((kind != EDIT_INS && w.len == 0) || (kind == EDIT_INS && w.len == LETTERS));
    case (kind)
      EDIT_SUB: begin
        pos = $urandom_range(w.len - 1);
        do begin
          sym = random_letter();
        end while (sym == w.letters[pos]);
        v.letters[pos] = sym;
      end
      EDIT_DEL: begin
        pos = $urandom_range(w.len - 1);
        for (k = pos; k < LETTERS - 1; k++) begin
          v.letters[k] = w.letters[k + 1];
        end
        v.letters[LETTERS-1] = '0;
        v.len = w.len - 1;
      end
      default: begin
        pos = $urandom_range(w.len);
        for (k = LETTERS - 1; k > pos; k--) begin
          v.letters[k] = w.letters[k - 1];
        end
        v.letters[pos] = random_letter();
        v.len = w.len + 1;
      end
    endcase
    return v;
  endfunction

  // Queues a request item. With dirty set, the unused letter positions carry
  // random bits, which the block must ignore.
  function automatic void send_word(logic kind, word_t w, bit dirty);
    word_req_t r;
    letters_t  bits;
    int        k;
    bits = w.letters;
    for (k = w.len; k < LETTERS; k++) begin
      bits[k] = dirty ? LETTER_W'($urandom) : '0;
    end
    r.req_type = kind;
    r.len      = LEN_W'(w.len);
    r.front    = bits[7:0];
    r.back     = bits[LETTERS-1:8];
    pending_reqs.insert(pending_reqs.size(), r);
    if (kind == REQ_LOAD && planned_words.size() < DICT_SLOTS) begin
      planned_words.insert(planned_words.size(), w);
    end
  endfunction

  function automatic word_t stored_pick();
    return planned_words[$urandom_range(planned_words.size() - 1)];
  endfunction

  // One random request item. Most loads are relatives of a few base words,
  // so families of near neighbors build up. Most queries land on or next to
  // a stored word; the rest are base words, two edits out or plain noise.
  function automatic void random_request();
    word_t w;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      if (pick < 6) begin
        w = random_word($urandom_range(LETTERS));
      end else if (pick < 26) begin
        w = edit_word(base_words[$urandom_range(base_words.size() - 1)]);
      end else if (pick < 36) begin
        w = edit_word(stored_pick());
      end else begin
        w = stored_pick();
      end
      send_word(REQ_LOAD, w, $urandom_range(1));
    end else begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        w = edit_word(stored_pick());
      end else if (pick < 55) begin
        w = stored_pick();
      end else if (pick < 75) begin
        w = base_words[$urandom_range(base_words.size() - 1)];
      end else if (pick < 88) begin
        w = edit_word(edit_word(stored_pick()));
      end else begin
        w = random_word($urandom_range(LETTERS));
      end
      send_word(REQ_CHECK, w, $urandom_range(1));
    end
  endfunction

  // Holds the sender back until every queued item has been taken and every
  // reply owed has come out.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_ch.valid || awaited_replies.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    word_t full_word;
    word_t zero_word;
    word_t odd_word;
    word_t trunc_base;
    int    k;

    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_LOAD;
    req_ch.word_len   = '0;
    req_ch.word_front = '0;
    req_ch.word_back  = '0;
    rsp_ch.ready      = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words. Slot numbers in the notes are what the block should
    // hand out, since the dictionary starts empty.
    full_word.letters = '1;
    full_word.len     = LETTERS;
    zero_word.letters = '0;
    zero_word.len     = LETTERS;
    odd_word          = word_of("abcdefg");
    odd_word.letters[0] = '0;
    for (k = 1; k < 5; k++) begin
      odd_word.letters[k] = LETTER_W'(26 + k);
    end

    send_word(REQ_CHECK, word_of("cat"), 1'b1);      // empty dictionary: none found
    send_word(REQ_LOAD,  word_of(""), 1'b1);         // empty word into slot 0
    send_word(REQ_CHECK, word_of(""), 1'b1);         // empty word is correct
    send_word(REQ_CHECK, word_of("a"), 1'b0);        // one insertion from empty
    send_word(REQ_LOAD,  full_word, 1'b0);           // all bits set, slot 1
    send_word(REQ_LOAD,  word_of("cat"), 1'b1);      // slot 2, junk past the end
    send_word(REQ_LOAD,  word_of("cat"), 1'b0);      // duplicate, slot 3
    send_word(REQ_CHECK, word_of("cat"), 1'b1);      // correct at the lower slot
    send_word(REQ_CHECK, word_of("bat"), 1'b0);      // substitution, both copies
    send_word(REQ_CHECK, word_of("at"), 1'b1);       // query one letter short
    send_word(REQ_CHECK, word_of("cart"), 1'b0);     // query one letter long
    send_word(REQ_CHECK, word_of("ca"), 1'b0);
    send_word(REQ_LOAD,  odd_word, 1'b1);            // codes 0 and 27..30, slot 4
    send_word(REQ_CHECK, odd_word, 1'b0);
    send_word(REQ_CHECK, edit_word(odd_word), 1'b1);
    send_word(REQ_CHECK, edit_word(full_word), 1'b0);
    full_word.letters[LETTERS-1] = '0;
    full_word.len = LETTERS - 1;
    send_word(REQ_CHECK, full_word, 1'b0);           // one short of slot 1
    send_word(REQ_CHECK, word_of("dog"), 1'b1);
    send_word(REQ_CHECK, zero_word, 1'b0);           // nothing near fifteen zeros
    send_word(REQ_LOAD,  zero_word, 1'b0);           // slot 5
    zero_word.len = LETTERS - 1;
    send_word(REQ_CHECK, zero_word, 1'b1);

    for (k = 0; k < 5; k++) begin
      base_words.insert(base_words.size(), random_word($urandom_range(LETTERS - 1, 1)));
    end

    // First half: the sender is mostly busy, the receiver often stalls.
    for (k = 0; k < RANDOM_REQS / 2; k++) begin
      random_request();
    end

    // Shut the response side for a long stretch while requests keep coming,
    // so the output fills and the block stops taking requests.
    @(posedge clk);
    rsp_hold = 1'b1;
    repeat (400) @(posedge clk);
    rsp_hold = 1'b0;
    wait_drained();

    // Second half: roles swapped.
    source_idle_pct = 61;
    sink_idle_pct   = 12;
    for (k = RANDOM_REQS / 2; k < RANDOM_REQS; k++) begin
      random_request();
    end
    wait_drained();

    // Last phase runs flat out on both sides.
    source_idle_pct = 0;
    sink_idle_pct   = 0;

    // Exactly as many neighbors as the suggestion limit, then a few more so
    // the list overflows and the last suggestion carries the truncated flag.
    trunc_base = random_word(6);
    repeat (SUGG_LIMIT) send_word(REQ_LOAD, edit_word(trunc_base), 1'b1);
    send_word(REQ_CHECK, trunc_base, 1'b0);
    repeat (3) send_word(REQ_LOAD, edit_word(trunc_base), 1'b1);
    send_word(REQ_CHECK, trunc_base, 1'b1);

    // A few closing items back to back.
    send_word(REQ_CHECK, edit_word(stored_pick()), 1'b1);
    send_word(REQ_CHECK, trunc_base, 1'b0);
    send_word(REQ_CHECK, random_word($urandom_range(LETTERS)), 1'b1);
    send_word(REQ_LOAD,  word_of("cat"), 1'b0);
    wait_drained();

    // Give any stray reply time to show up before calling it.
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("dictionary_one_edit_matcher_tb: clean");
    end else begin
      $display("dictionary_one_edit_matcher_tb: errors");
    end
    $finish;
  end

endmodule
